>>> rtl/core/sbec_pkg.sv
package sbec_pkg;

  // Spectrum geometry and sum width
  localparam int NUM_BINS = 64;
  localparam int SUM_W    = 48;
  localparam int MAG_W    = 16;
  localparam int SQR_W    = 2 * MAG_W;
  localparam int BIAS_W   = 8;
  localparam int PROD_W   = SUM_W + BIAS_W;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TREMOR_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DYSK_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TREMOR_LO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TREMOR_HI   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DYSK_LO     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DYSK_HI     = 3'd7;

  // Register defaults
  localparam logic [15:0] RST_WINDOW_MS  = 16'd2000;
  localparam logic [31:0] RST_TREMOR_THR = 32'd80000;
  localparam logic [31:0] RST_DYSK_THR   = 32'd70000;
  localparam logic [7:0]  RST_BIAS       = 8'd32;
  localparam logic [5:0]  RST_TREMOR_LO  = 6'd3;
  localparam logic [6:0]  RST_TREMOR_HI  = 7'd5;
  localparam logic [5:0]  RST_DYSK_LO    = 6'd5;
  localparam logic [6:0]  RST_DYSK_HI    = 7'd7;

  // Input item kinds
  localparam logic FUNC_BIN  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Result classes
  localparam logic [1:0] CLASS_NORMAL = 2'd0;
  localparam logic [1:0] CLASS_TREMOR = 2'd1;
  localparam logic [1:0] CLASS_DYSK   = 2'd2;

  typedef struct packed {
    logic load;     // capture the accepted transaction
    logic exec;     // accumulate or count a tick
    logic compare;  // register threshold flags and ratio product
    logic emit;     // load the result register and clear the window
  } sbec_cmd_t;

  typedef struct packed {
    logic close_hit;  // item in work closes the window
    logic out_free;   // result register can take a new transaction
  } sbec_status_t;

endpackage

>>> rtl/core/spectral_band_energy_classifier_top.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    func, bin_index, magnitude, last_bin
// out_      output     out_valid/out_ready  motion_class, three 48-bit energies
// cfg_      input      cfg_wr_en            cfg_index, cfg_wdata (32 bits)
//
// A bin or tick transaction is captured with the square, then the shared datapath
// does the saturating accumulate or tick count.
// A window-closing bin is captured, then goes through accumulate, compare with the ratio product,
// then load of the result register, which waits while that register is still full.
// rst_n is synchronous: it clears the sums, the window and the result valid flag
// and restores the register defaults.
// Input is taken while an earlier result waits; only a closing bin stalls on out_ready.
module spectral_band_energy_classifier_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [sbec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbec_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [5:0]                      in_bin_index,
  input  logic [sbec_pkg::MAG_W-1:0]      in_magnitude,
  input  logic                            in_last_bin,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_motion_class,
  output logic [sbec_pkg::SUM_W-1:0]      out_tremor_energy,
  output logic [sbec_pkg::SUM_W-1:0]      out_dysk_energy,
  output logic [sbec_pkg::SUM_W-1:0]      out_total_energy
);
  import sbec_pkg::*;

  sbec_cmd_t    cmd;
  sbec_status_t status;

  sbec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sbec_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_func           (in_func),
    .in_bin_index      (in_bin_index),
    .in_magnitude      (in_magnitude),
    .in_last_bin       (in_last_bin),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motion_class  (out_motion_class),
    .out_tremor_energy (out_tremor_energy),
    .out_dysk_energy   (out_dysk_energy),
    .out_total_energy  (out_total_energy),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

>>> rtl/core/sbec_ctrl.sv
module sbec_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sbec_pkg::sbec_status_t status,
  output sbec_pkg::sbec_cmd_t    cmd
);
  import sbec_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CMP,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = status.close_hit ? S_CMP : S_IDLE;
      end
      S_CMP: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold until the result register drains
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.load    = (state_r == S_IDLE) && in_valid;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.compare = (state_r == S_CMP);
  assign cmd.emit    = (state_r == S_EMIT) && status.out_free;

endmodule

>>> rtl/core/sbec_datapath.sv
module sbec_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [sbec_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sbec_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_func,
  input  logic [5:0]                             in_bin_index,
  input  logic [sbec_pkg::MAG_W-1:0]             in_magnitude,
  input  logic                                   in_last_bin,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             out_motion_class,
  output logic [sbec_pkg::SUM_W-1:0]             out_tremor_energy,
  output logic [sbec_pkg::SUM_W-1:0]             out_dysk_energy,
  output logic [sbec_pkg::SUM_W-1:0]             out_total_energy,
  input  sbec_pkg::sbec_cmd_t                    cmd,
  output sbec_pkg::sbec_status_t                 status
);
  import sbec_pkg::*;

  // Configuration registers
  logic [15:0]       window_r;
  logic [31:0]       tremor_thr_r;
  logic [31:0]       dysk_thr_r;
  logic [BIAS_W-1:0] bias_r;
  logic [5:0]        tremor_lo_r;
  logic [6:0]        tremor_hi_r;
  logic [5:0]        dysk_lo_r;
  logic [6:0]        dysk_hi_r;

  // Item in work
  logic              func_r;
  logic [5:0]        bin_r;
  logic              last_r;
  logic [SQR_W-1:0]  energy_r;

  // Window state
  logic [SUM_W-1:0]  tremor_sum_r;
  logic [SUM_W-1:0]  dysk_sum_r;
  logic [SUM_W-1:0]  total_sum_r;
  logic [15:0]       elapsed_r;
  logic              accum_r;

  // Decision stage
  logic              t_hit_r;
  logic              d_hit_r;
  logic [PROD_W-1:0] prod_r;

  // Result register
  logic              out_valid_r;
  logic [1:0]        class_r;
  logic [SUM_W-1:0]  out_tremor_r;
  logic [SUM_W-1:0]  out_dysk_r;
  logic [SUM_W-1:0]  out_total_r;

  logic              is_bin;
  logic              bin_ok;
  logic              in_tremor;
  logic              in_dysk;
  logic [15:0]       elapsed_eff;
  logic [SUM_W:0]    total_add;
  logic [SUM_W:0]    tremor_add;
  logic [SUM_W:0]    dysk_add;
  logic [SUM_W-1:0]  total_sat;
  logic [SUM_W-1:0]  tremor_sat;
  logic [SUM_W-1:0]  dysk_sat;
  logic [1:0]        class_nxt;

  assign is_bin      = (func_r == FUNC_BIN);
  assign bin_ok      = (bin_r != 6'd0) && (int'(bin_r) < NUM_BINS);
  assign in_tremor   = ({1'b0, bin_r} >= {1'b0, tremor_lo_r}) && ({1'b0, bin_r} < tremor_hi_r);
  assign in_dysk     = ({1'b0, bin_r} >= {1'b0, dysk_lo_r}) && ({1'b0, bin_r} < dysk_hi_r);
  // a bin that opens a window sees zero elapsed time
  assign elapsed_eff = accum_r ? elapsed_r : 16'd0;

  assign total_add  = {1'b0, total_sum_r} + {{(SUM_W + 1 - SQR_W){1'b0}}, energy_r};
  assign tremor_add = {1'b0, tremor_sum_r} + {{(SUM_W + 1 - SQR_W){1'b0}}, energy_r};
  assign dysk_add   = {1'b0, dysk_sum_r} + {{(SUM_W + 1 - SQR_W){1'b0}}, energy_r};
  assign total_sat  = total_add[SUM_W] ? SUM_MAX : total_add[SUM_W-1:0];
  assign tremor_sat = tremor_add[SUM_W] ? SUM_MAX : tremor_add[SUM_W-1:0];
  assign dysk_sat   = dysk_add[SUM_W] ? SUM_MAX : dysk_add[SUM_W-1:0];

  assign status.close_hit = is_bin && last_r && (elapsed_eff >= window_r);
  assign status.out_free  = !out_valid_r || out_ready;

  always_comb begin
    if (!t_hit_r && !d_hit_r) begin
      class_nxt = CLASS_NORMAL;
    end else if (t_hit_r && !d_hit_r) begin
      class_nxt = CLASS_TREMOR;
    end else if (!t_hit_r && d_hit_r) begin
      class_nxt = CLASS_DYSK;
    end else if ({{BIAS_W - 4{1'b0}}, tremor_sum_r, 4'b0000} < prod_r) begin
      class_nxt = CLASS_DYSK;
    end else begin
      class_nxt = CLASS_TREMOR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= RST_WINDOW_MS;
      tremor_thr_r <= RST_TREMOR_THR;
      dysk_thr_r   <= RST_DYSK_THR;
      bias_r       <= RST_BIAS;
      tremor_lo_r  <= RST_TREMOR_LO;
      tremor_hi_r  <= RST_TREMOR_HI;
      dysk_lo_r    <= RST_DYSK_LO;
      dysk_hi_r    <= RST_DYSK_HI;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WINDOW_MS:  window_r     <= cfg_wdata[15:0];
        REG_TREMOR_THR: tremor_thr_r <= cfg_wdata;
        REG_DYSK_THR:   dysk_thr_r   <= cfg_wdata;
        REG_BIAS:       bias_r       <= cfg_wdata[BIAS_W-1:0];
        REG_TREMOR_LO:  tremor_lo_r  <= cfg_wdata[5:0];
        REG_TREMOR_HI:  tremor_hi_r  <= cfg_wdata[6:0];
        REG_DYSK_LO:    dysk_lo_r    <= cfg_wdata[5:0];
        REG_DYSK_HI:    dysk_hi_r    <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      bin_r    <= in_bin_index;
      last_r   <= in_last_bin;
      energy_r <= SQR_W'(in_magnitude) * SQR_W'(in_magnitude);
    end
    if (cmd.compare) begin
      t_hit_r <= tremor_sum_r > {{(SUM_W - 32){1'b0}}, tremor_thr_r};
      d_hit_r <= dysk_sum_r > {{(SUM_W - 32){1'b0}}, dysk_thr_r};
      prod_r  <= PROD_W'(dysk_sum_r) * PROD_W'(bias_r);
    end
    if (cmd.emit) begin
      class_r      <= class_nxt;
      out_tremor_r <= tremor_sum_r;
      out_dysk_r   <= dysk_sum_r;
      out_total_r  <= total_sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tremor_sum_r <= '0;
      dysk_sum_r   <= '0;
      total_sum_r  <= '0;
      elapsed_r    <= '0;
      accum_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.exec) begin
        if (is_bin) begin
          if (!accum_r) begin
            accum_r   <= 1'b1;
            elapsed_r <= '0;
          end
          if (bin_ok) begin
            total_sum_r <= total_sat;
            // tremor band takes the overlap
            if (in_tremor) begin
              tremor_sum_r <= tremor_sat;
            end else if (in_dysk) begin
              dysk_sum_r <= dysk_sat;
            end
          end
        end else if (accum_r && (elapsed_r != 16'hFFFF)) begin
          elapsed_r <= elapsed_r + 16'd1;
        end
      end
      if (cmd.emit) begin
        tremor_sum_r <= '0;
        dysk_sum_r   <= '0;
        total_sum_r  <= '0;
        elapsed_r    <= '0;
        accum_r      <= 1'b0;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_motion_class  = class_r;
  assign out_tremor_energy = out_tremor_r;
  assign out_dysk_energy   = out_dysk_r;
  assign out_total_energy  = out_total_r;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sbec_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 450;
  localparam int MIN_WINDOWS   = 40;
  localparam int MAX_PRINTS    = 200;

  typedef struct packed {
    logic             func;
    logic [5:0]       bin_index;
    logic [MAG_W-1:0] magnitude;
    logic             last_bin;
  } bin_item_t;

  typedef struct packed {
    logic [1:0]       motion_class;
    logic [SUM_W-1:0] tremor_energy;
    logic [SUM_W-1:0] dysk_energy;
    logic [SUM_W-1:0] total_energy;
  } energy_report_t;

  class band_energy_scoreboard;
    logic [15:0]      window_ms;
    logic [31:0]      tremor_thr;
    logic [31:0]      dysk_thr;
    logic [7:0]       bias;
    logic [5:0]       tremor_lo;
    logic [6:0]       tremor_hi;
    logic [5:0]       dysk_lo;
    logic [6:0]       dysk_hi;
    logic [SUM_W-1:0] tremor_sum;
    logic [SUM_W-1:0] dysk_sum;
    logic [SUM_W-1:0] total_sum;
    logic [15:0]      elapsed;
    bit               in_window;
    energy_report_t   pending_windows[$];
    int               errors;
    int               windows_closed;

    function new();
      window_ms  = RST_WINDOW_MS;
      tremor_thr = RST_TREMOR_THR;
      dysk_thr   = RST_DYSK_THR;
      bias       = RST_BIAS;
      tremor_lo  = RST_TREMOR_LO;
      tremor_hi  = RST_TREMOR_HI;
      dysk_lo    = RST_DYSK_LO;
      dysk_hi    = RST_DYSK_HI;
      errors = 0;
      windows_closed = 0;
      clear_window();
    endfunction

    function void clear_window();
      tremor_sum = '0;
      dysk_sum   = '0;
      total_sum  = '0;
      elapsed    = '0;
      in_window  = 1'b0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WINDOW_MS:  window_ms  = data[15:0];
        REG_TREMOR_THR: tremor_thr = data;
        REG_DYSK_THR:   dysk_thr   = data;
        REG_BIAS:       bias       = data[7:0];
        REG_TREMOR_LO:  tremor_lo  = data[5:0];
        REG_TREMOR_HI:  tremor_hi  = data[6:0];
        REG_DYSK_LO:    dysk_lo    = data[5:0];
        REG_DYSK_HI:    dysk_hi    = data[6:0];
        default: ;
      endcase
    endfunction

    function logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] acc, logic [SQR_W-1:0] sq);
      logic [SUM_W:0] s;
      s = {1'b0, acc} + {{(SUM_W + 1 - SQR_W){1'b0}}, sq};
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function logic [1:0] classify();
      logic [63:0] tremor_scaled;
      logic [63:0] dysk_scaled;
      bit          t_hit;
      bit          d_hit;
      t_hit = tremor_sum > SUM_W'(tremor_thr);
      d_hit = dysk_sum > SUM_W'(dysk_thr);
      if (!t_hit && !d_hit) return CLASS_NORMAL;
      if (!d_hit) return CLASS_TREMOR;
      if (!t_hit) return CLASS_DYSK;
      tremor_scaled = {12'b0, tremor_sum, 4'b0};
      dysk_scaled = {16'b0, dysk_sum};
      dysk_scaled = dysk_scaled * 64'(bias);
      return (tremor_scaled < dysk_scaled) ? CLASS_DYSK : CLASS_TREMOR;
    endfunction

    function void note_input(bin_item_t it);
      logic [SQR_W-1:0] sq;
      energy_report_t   r;
      if (it.func == FUNC_TICK) begin
        if (in_window && elapsed != 16'hFFFF) elapsed++;
        return;
      end
      if (!in_window) begin
        in_window = 1'b1;
        elapsed = '0;
      end
      if (it.bin_index >= 1 && it.bin_index < NUM_BINS) begin
        sq = SQR_W'(it.magnitude) * SQR_W'(it.magnitude);
        total_sum = sat_add(total_sum, sq);
        // overlapping bins go to the tremor band only
        if (it.bin_index >= tremor_lo && {1'b0, it.bin_index} < tremor_hi)
          tremor_sum = sat_add(tremor_sum, sq);
        else if (it.bin_index >= dysk_lo && {1'b0, it.bin_index} < dysk_hi)
          dysk_sum = sat_add(dysk_sum, sq);
      end
      if (it.last_bin && elapsed >= window_ms) begin
        r.motion_class  = classify();
        r.tremor_energy = tremor_sum;
        r.dysk_energy   = dysk_sum;
        r.total_energy  = total_sum;
        pending_windows.push_back(r);
        clear_window();
      end
    endfunction

    function int pending();
      return pending_windows.size();
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(energy_report_t got);
      energy_report_t want;
      if (pending_windows.size() == 0) begin
        report($sformatf("unexpected result, class %0d total %0d",
                         got.motion_class, got.total_energy));
        return;
      end
      want = pending_windows.pop_front();
      windows_closed++;
      if (got.motion_class !== want.motion_class)
        report($sformatf("motion_class got %0d expected %0d",
                         got.motion_class, want.motion_class));
      if (got.tremor_energy !== want.tremor_energy)
        report($sformatf("tremor_energy got %0d expected %0d",
                         got.tremor_energy, want.tremor_energy));
      if (got.dysk_energy !== want.dysk_energy)
        report($sformatf("dysk_energy got %0d expected %0d",
                         got.dysk_energy, want.dysk_energy));
      if (got.total_energy !== want.total_energy)
        report($sformatf("total_energy got %0d expected %0d",
                         got.total_energy, want.total_energy));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_func = FUNC_BIN;
  logic [5:0]            in_bin_index = '0;
  logic [MAG_W-1:0]      in_magnitude = '0;
  logic                  in_last_bin = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_motion_class;
  logic [SUM_W-1:0]      out_tremor_energy;
  logic [SUM_W-1:0]      out_dysk_energy;
  logic [SUM_W-1:0]      out_total_energy;

  band_energy_scoreboard energy_sb;
  int unsigned           items_sent = 0;
  int unsigned           burst_left = 0;
  bit                    hold_req = 1'b0;
  int                    held = 0;
  int                    ready_run = 0;
  bit                    ready_level = 1'b0;

  spectral_band_energy_classifier_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_bin_index      (in_bin_index),
    .in_magnitude      (in_magnitude),
    .in_last_bin       (in_last_bin),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motion_class  (out_motion_class),
    .out_tremor_energy (out_tremor_energy),
    .out_dysk_energy   (out_dysk_energy),
    .out_total_energy  (out_total_energy)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid === 1'b1 && in_ready === 1'b1)
        energy_sb.note_input({in_func, in_bin_index, in_magnitude, in_last_bin});
      if (out_valid === 1'b1 && out_ready === 1'b1)
        energy_sb.check_result({out_motion_class, out_tremor_energy,
                                out_dysk_energy, out_total_energy});
    end
  end

  // Receiver: alternate ready runs, with a long counted hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          hold_req = 1'b0;
          held = 0;
        end
      end else begin
        if (ready_run == 0) begin
          ready_level = !ready_level;
          if (ready_level)
            ready_run = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 10);
          else
            ready_run = $urandom_range(1, 6);
        end
        ready_run--;
        out_ready <= ready_level;
      end
    end
  end

  task automatic drive_item(bin_item_t it);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_func      <= it.func;
    in_bin_index <= it.bin_index;
    in_magnitude <= it.magnitude;
    in_last_bin  <= it.last_bin;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
  endtask

  task automatic pause_sender(int unsigned n);
    if (n == 0) return;
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic offer(bin_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
    end
    burst_left--;
    drive_item(it);
  endtask

  task automatic offer_bin(logic [5:0] bin, logic [MAG_W-1:0] mag, logic last);
    bin_item_t it;
    it.func      = FUNC_BIN;
    it.bin_index = bin;
    it.magnitude = mag;
    it.last_bin  = last;
    offer(it);
  endtask

  // the other fields of a tick carry junk
  task automatic offer_tick();
    bin_item_t it;
    it = 24'($urandom);
    it.func = FUNC_TICK;
    offer(it);
  endtask

  // Hold input, wait for every outstanding window result, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (energy_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value, int width);
    logic [31:0] data;
    data = (width < 32) ? (value | ($urandom << width)) : value;
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    energy_sb.set_register(idx, data);
  endtask

  task automatic configure(logic [15:0] win, logic [31:0] t_thr, logic [31:0] d_thr,
                           logic [7:0] bias, logic [5:0] t_lo, logic [6:0] t_hi,
                           logic [5:0] d_lo, logic [6:0] d_hi);
    drain();
    write_register(REG_WINDOW_MS, win, 16);
    write_register(REG_TREMOR_THR, t_thr, 32);
    write_register(REG_DYSK_THR, d_thr, 32);
    write_register(REG_BIAS, bias, 8);
    write_register(REG_TREMOR_LO, t_lo, 6);
    write_register(REG_TREMOR_HI, t_hi, 7);
    write_register(REG_DYSK_LO, d_lo, 6);
    write_register(REG_DYSK_HI, d_hi, 7);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] pick_threshold();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2000);
      1: return $urandom_range(0, 50_000_000);
      2: return $urandom_range(32'd100_000_000, 32'hFFFF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [MAG_W-1:0] pick_magnitude();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return MAG_W'($urandom_range(0, 300));
      default: return MAG_W'($urandom);
    endcase
  endfunction

  // One spectrum sweep with ticks sprinkled in; drop the last mark when broken
  task automatic spectrum(bit closed);
    int unsigned n;
    int unsigned start;
    n = $urandom_range(1, 10);
    start = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 20);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) offer_tick();
      offer_bin(6'(start + k), pick_magnitude(), closed && (k == n - 1));
    end
  endtask

  task automatic random_phase(int unsigned n_items, bit with_hold, bit with_pause);
    int unsigned first;
    logic [5:0]  t_lo;
    logic [6:0]  t_hi;
    logic [5:0]  d_lo;
    logic [6:0]  d_hi;
    bin_item_t   it;
    t_lo = 6'($urandom_range(0, 16));
    t_hi = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'(t_lo + $urandom_range(1, 8));
    d_lo = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'(t_lo + $urandom_range(0, 8));
    d_hi = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'(d_lo + $urandom_range(1, 10));
    configure(16'($urandom_range(0, 6)), pick_threshold(), pick_threshold(),
              8'($urandom_range(0, 255)), t_lo, t_hi, d_lo, d_hi);
    if (with_hold) hold_req = 1'b1;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if (with_pause && items_sent - first >= n_items / 2) begin
        drain();
        with_pause = 1'b0;
      end
      case ($urandom_range(0, 9))
        0: begin
          it = 24'($urandom);
          offer(it);
        end
        1: spectrum(1'b0);
        default: spectrum(1'b1);
      endcase
    end
  endtask

  initial begin
    int unsigned items_before;
    int          closed_before;
    int          phase;
    energy_sb = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults: idle tick, early last mark, then a short window
    offer_tick();
    offer_bin(3, 300, 1'b0);
    offer_bin(4, 16'hFFFF, 1'b0);
    offer_bin(5, 300, 1'b0);
    offer_bin(6, 200, 1'b0);
    offer_bin(0, 1000, 1'b0);
    offer_bin(63, 100, 1'b1);
    drain();
    write_register(REG_WINDOW_MS, 2, 16);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    repeat (2) offer_tick();
    offer_bin(7, 5, 1'b1);

    // Zero window, overlapping bands, every class and the equal-ratio boundary
    configure(0, 100, 100, 16, 2, 4, 3, 8);
    offer_bin(0, 16'hFFFF, 1'b1);
    offer_bin(2, 5, 1'b1);
    offer_bin(2, 11, 1'b1);
    offer_bin(3, 11, 1'b1);
    offer_bin(5, 11, 1'b1);
    offer_bin(2, 20, 1'b0);
    offer_bin(5, 20, 1'b1);
    offer_bin(2, 20, 1'b0);
    offer_bin(5, 21, 1'b1);
    offer_bin(63, 16'hFFFF, 1'b0);
    offer_bin(1, 1, 1'b1);
    offer_bin(10, 0, 1'b1);

    // Zero bias with both bands hit, band end past the spectrum, early last mark
    configure(3, 0, 0, 0, 1, 2, 60, 127);
    offer_bin(1, 3, 1'b1);
    repeat (3) offer_tick();
    offer_bin(61, 50, 1'b1);

    // Reversed tremor band
    configure(0, 0, 0, 255, 63, 0, 0, 64);
    offer_tick();
    offer_bin(63, 9, 1'b1);

    items_before = items_sent;
    closed_before = energy_sb.windows_closed;
    phase = 0;
    while (items_sent - items_before < RANDOM_ITEMS
           || energy_sb.windows_closed - closed_before < MIN_WINDOWS) begin
      random_phase(75, phase == 1, phase == 3);
      phase++;
    end

    drain();
    if (energy_sb.errors == 0 && energy_sb.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #24_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
